/* rtl/ddof_pkg.sv */
// Shared types, codes and helpers of the decay daughter overlap filter.
// No dependencies; every other file of the block imports this package.
package ddof_pkg;

    localparam int TABLE_DEPTH_DEF = 64;
    localparam int QUEUE_DEPTH     = 2;   // must be a power of two
    localparam int MOM_W           = 32;
    localparam int CNT_W           = 8;
    localparam int DIV_STEPS       = 32;

    // Operation codes of an input item.
    localparam logic [1:0] OP_LAMBDA = 2'd0;
    localparam logic [1:0] OP_KSHORT = 2'd1;
    localparam logic [1:0] OP_END    = 2'd2;

    // Result kinds.
    localparam logic KIND_VERDICT  = 1'b0;
    localparam logic KIND_DECISION = 1'b1;

    // Register indexes of the configuration port.
    localparam logic [1:0] REG_MODE     = 2'd0;
    localparam logic [1:0] REG_MIN_LAM  = 2'd1;
    localparam logic [1:0] REG_MIN_KSH  = 2'd2;
    localparam logic [1:0] REG_PRESCALE = 2'd3;

    typedef struct packed {
        logic [1:0]         op;
        logic [3*MOM_W-1:0] mom;
        logic               last;
    } t_item;

    typedef struct packed {
        logic             valid;
        logic             kind;
        logic             kept;
        logic             accept;
        logic [CNT_W-1:0] lam;
        logic [CNT_W-1:0] ksh;
        logic             ovf;
    } t_result;

    typedef struct packed {
        logic done;
        logic zero;
    } t_rem_status;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v == {CNT_W{1'b1}}) ? v : v + CNT_W'(1);
    endfunction

endpackage

/* rtl/ddof_front.sv */
// Front end: accepts items, drops those that cause no work, and queues the rest.
// Depends on ddof_pkg.
module ddof_front
    import ddof_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [1:0]           i_op,
    input  logic [3*MOM_W-1:0]   i_mom,
    input  logic                 i_last,
    input  logic                 i_data_mode,
    input  logic                 i_pop,
    output logic                 o_busy,
    output logic                 o_avail,
    output t_item                o_head
);

    localparam int QAW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [QCW-1:0] QD_C = QCW'(QUEUE_DEPTH);

    t_item          r_q [QUEUE_DEPTH];
    logic [QAW-1:0] r_wp, r_rp;
    logic [QCW-1:0] r_cnt;
    logic           accept, push, pop;

    assign o_busy  = (r_cnt == QD_C);
    assign o_avail = (r_cnt != '0);
    assign o_head  = r_q[r_rp];
    assign accept  = i_start && !o_busy;
    // Operation code 3 does nothing, and lambda daughters mean nothing
    // when the block runs on simulated input.
    assign push    = accept && ((i_op == OP_KSHORT) || (i_op == OP_END) ||
                                ((i_op == OP_LAMBDA) && i_data_mode));
    assign pop     = i_pop && o_avail;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= '{op: i_op, mom: i_mom, last: i_last};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) r_wp <= r_wp + QAW'(1);
            if (pop)  r_rp <= r_rp + QAW'(1);
            r_cnt <= r_cnt + QCW'(push) - QCW'(pop);
        end
    end

endmodule

/* rtl/ddof_rem.sv */
// Iterative remainder unit: one restoring step per cycle, 32 steps.
// Depends on ddof_pkg.
module ddof_rem
    import ddof_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [31:0]       i_num,
    input  logic [31:0]       i_den,
    output t_rem_status       o_status
);

    localparam int SW = $clog2(DIV_STEPS + 1);

    logic [31:0]   r_num, r_den, r_rem;
    logic [SW-1:0] r_steps;
    logic          r_done;
    logic [32:0]   trial;

    assign trial = {r_rem, r_num[31]};

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= '0;
        end else if (r_steps != '0) begin
            r_num <= {r_num[30:0], 1'b0};
            if (trial >= {1'b0, r_den}) begin
                r_rem <= 32'(trial - {1'b0, r_den});
            end else begin
                r_rem <= trial[31:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_steps <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= (r_steps == SW'(1)) && !i_start;
            if (i_start) begin
                r_steps <= SW'(DIV_STEPS);
            end else if (r_steps != '0) begin
                r_steps <= r_steps - SW'(1);
            end
        end
    end

    assign o_status = '{done: r_done, zero: (r_rem == '0)};

endmodule

/* rtl/ddof_back.sv */
// Back end: daughter table, table scan, event counters and the event decision.
// Depends on ddof_pkg and ddof_rem.
module ddof_back
    import ddof_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_avail,
    input  t_item              i_head,
    output logic               o_pop,
    input  logic               i_data_mode,
    input  logic [CNT_W-1:0]   i_min_lam,
    input  logic [CNT_W-1:0]   i_min_ksh,
    input  logic [31:0]        i_prescale,
    output t_result            o_result
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int FW = $clog2(TABLE_DEPTH + 1);
    localparam logic [FW-1:0] DEPTH_F = FW'(TABLE_DEPTH);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SCAN  = 4'b0010,
        S_DRAIN = 4'b0100,
        S_DIV   = 4'b1000
    } t_state;

    t_state             r_state, n_state;
    logic [FW-1:0]      r_fill, n_fill;
    logic [CNT_W-1:0]   r_lam, n_lam, r_ksh, n_ksh;
    logic               r_ovl, n_ovl, r_ovf, n_ovf;
    logic [31:0]        r_rej, n_rej;
    logic [AW-1:0]      r_addr, n_addr;
    logic [3*MOM_W-1:0] r_key, n_key;
    logic               r_last, n_last;
    t_result            r_res, n_res;

    logic [3*MOM_W-1:0] mem [TABLE_DEPTH];
    logic [3*MOM_W-1:0] r_rd;
    logic               r_cmp_vld;

    logic               mem_we, div_start, match, fail;
    logic               fin_ks, fin_ovl, keep_ovl, fin_evt, evt_acc, ks_kept;
    logic [31:0]        rej_inc;
    logic [AW-1:0]      last_idx;
    t_rem_status        rem_st;

    ddof_rem u_rem (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (div_start),
        .i_num    (rej_inc),
        .i_den    (i_prescale),
        .o_status (rem_st)
    );

    assign match    = r_cmp_vld && (r_rd == r_key);
    assign last_idx = AW'(r_fill - FW'(1));
    assign rej_inc  = r_rej + 32'd1;
    assign fail     = (r_lam < i_min_lam) || (r_ksh < i_min_ksh);
    assign o_result = r_res;

    always_comb begin
        n_state   = r_state;
        n_fill    = r_fill;
        n_lam     = r_lam;
        n_ksh     = r_ksh;
        n_ovl     = r_ovl;
        n_ovf     = r_ovf;
        n_rej     = r_rej;
        n_addr    = r_addr;
        n_key     = r_key;
        n_last    = r_last;
        n_res     = r_res;
        n_res.valid = 1'b0;
        o_pop     = 1'b0;
        mem_we    = 1'b0;
        div_start = 1'b0;
        fin_ks    = 1'b0;
        fin_ovl   = 1'b0;
        keep_ovl  = 1'b0;
        fin_evt   = 1'b0;
        evt_acc   = 1'b0;
        ks_kept   = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_avail) begin
                    o_pop = 1'b1;
                    case (i_head.op)
                        OP_LAMBDA: begin
                            if (r_fill < DEPTH_F) begin
                                mem_we = 1'b1;
                                n_fill = r_fill + FW'(1);
                            end else begin
                                n_ovf = 1'b1;
                            end
                            if (i_head.last) n_lam = sat_inc(r_lam);
                        end
                        OP_KSHORT: begin
                            if (i_data_mode && (r_fill != '0)) begin
                                n_key   = i_head.mom;
                                n_last  = i_head.last;
                                n_addr  = '0;
                                n_state = S_SCAN;
                            end else if (i_head.last) begin
                                fin_ks  = 1'b1;
                                fin_ovl = r_ovl;
                            end
                        end
                        default: begin
                            // End of event.
                            if (fail && (i_prescale != '0)) begin
                                n_rej     = rej_inc;
                                div_start = 1'b1;
                                n_state   = S_DIV;
                            end else begin
                                if (fail) n_rej = rej_inc;
                                fin_evt = 1'b1;
                                evt_acc = !fail;
                            end
                        end
                    endcase
                end
            end
            S_SCAN: begin
                n_ovl  = r_ovl | match;
                n_addr = r_addr + AW'(1);
                if (r_addr == last_idx) n_state = S_DRAIN;
            end
            S_DRAIN: begin
                n_state = S_IDLE;
                if (r_last) begin
                    fin_ks  = 1'b1;
                    fin_ovl = r_ovl | match;
                end else begin
                    keep_ovl = 1'b1;
                end
            end
            S_DIV: begin
                if (rem_st.done) begin
                    fin_evt = 1'b1;
                    evt_acc = rem_st.zero;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        if (keep_ovl) n_ovl = r_ovl | match;

        if (fin_ks) begin
            ks_kept = i_data_mode && !fin_ovl;
            if (ks_kept) n_ksh = sat_inc(r_ksh);
            n_ovl = 1'b0;
            n_res = '{valid: 1'b1, kind: KIND_VERDICT, kept: ks_kept, accept: 1'b0,
                      lam: r_lam, ksh: n_ksh, ovf: r_ovf};
        end

        if (fin_evt) begin
            n_res  = '{valid: 1'b1, kind: KIND_DECISION, kept: 1'b0, accept: evt_acc,
                       lam: r_lam, ksh: r_ksh, ovf: r_ovf};
            n_fill = '0;
            n_lam  = '0;
            n_ksh  = '0;
            n_ovl  = 1'b0;
            n_ovf  = 1'b0;
        end
    end

    // Daughter table: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[r_fill[AW-1:0]] <= i_head.mom;
        end
        r_rd <= mem[r_addr];
    end

    always_ff @(posedge i_clk) begin
        r_key  <= n_key;
        r_last <= n_last;
        r_addr <= n_addr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_lam       <= '0;
            r_ksh       <= '0;
            r_ovl       <= 1'b0;
            r_ovf       <= 1'b0;
            r_rej       <= '0;
            r_cmp_vld   <= 1'b0;
            r_res       <= '0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_lam       <= n_lam;
            r_ksh       <= n_ksh;
            r_ovl       <= n_ovl;
            r_ovf       <= n_ovf;
            r_rej       <= n_rej;
            r_cmp_vld   <= (r_state == S_SCAN);
            r_res       <= n_res;
        end
    end

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= DEPTH_F)
        else $error("daughter table fill beyond its depth");

    a_drain_has_compare: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DRAIN) |-> r_cmp_vld)
        else $error("drain state without a pending table compare");

    a_scan_needs_entries: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_fill != '0) && (r_addr <= last_idx))
        else $error("table scan outside the filled entries");

    a_div_prescale: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (i_prescale != '0))
        else $error("remainder unit running with a zero prescale");

    a_verdict_no_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_res.valid && (r_res.kind == KIND_VERDICT)) |-> !r_res.accept)
        else $error("kshort verdict carries an event accept");

endmodule

/* rtl/decay_daughter_overlap_filter.sv */
// Top level of the decay daughter overlap filter: ports, configuration registers
// and the connection of front end and back end. Depends on ddof_pkg,
// ddof_front and ddof_back.
//
//   channel   | handshake                        | payload
//   ----------+----------------------------------+-----------------------------------
//   input     | start, busy (taken: start & !busy) | i_operation, i_mom_x/y/z,
//             |                                  | i_last_daughter
//   result    | o_result_valid, one-cycle strobe | o_result_kind, o_kshort_kept, ...
//   config    | APB psel/penable/pwrite, pready=1 | paddr, pwdata, prdata
//
// A lambda daughter is handled in the back end's idle state. A kshort daughter
// starts a table scan, one stored daughter per cycle, then a drain state; there
// is no scan when the table is empty or in simulation mode. An end-of-event item
// is decided in the idle state or, for a failing event with a nonzero prescale,
// in the divide state once the iterative remainder unit is done. Reset is
// synchronous and active low; it clears the counters and flags, not the daughter
// table, which is only read below its fill count. A two-item queue sits between
// front and back, so busy rises only when it is full; the result side cannot
// stall, and each result is shown for exactly one cycle.
module decay_daughter_overlap_filter
    import ddof_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // Input items.
    input  logic                start,
    output logic                busy,
    input  logic [1:0]          i_operation,
    input  logic [MOM_W-1:0]    i_mom_x,
    input  logic [MOM_W-1:0]    i_mom_y,
    input  logic [MOM_W-1:0]    i_mom_z,
    input  logic                i_last_daughter,
    // Results.
    output logic                o_result_valid,
    output logic                o_result_kind,
    output logic                o_kshort_kept,
    output logic                o_event_accept,
    output logic [CNT_W-1:0]    o_lambda_total,
    output logic [CNT_W-1:0]    o_kshort_total,
    output logic                o_table_overflow,
    // Configuration port.
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    logic             r_mode;
    logic [CNT_W-1:0] r_min_lam, r_min_ksh;
    logic [31:0]      r_prescale;
    logic             cfg_we;

    logic             q_avail, q_pop;
    t_item            q_head;
    t_result          res;

    // Registers are written in the access phase; the port never waits.
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= 1'b1;
            r_min_lam  <= CNT_W'(1);
            r_min_ksh  <= CNT_W'(1);
            r_prescale <= '0;
        end else if (cfg_we) begin
            unique case (paddr[3:2])
                REG_MODE:     r_mode     <= pwdata[0];
                REG_MIN_LAM:  r_min_lam  <= pwdata[CNT_W-1:0];
                REG_MIN_KSH:  r_min_ksh  <= pwdata[CNT_W-1:0];
                REG_PRESCALE: r_prescale <= pwdata;
                default:      ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_MODE:     prdata = {31'd0, r_mode};
            REG_MIN_LAM:  prdata = {{(32-CNT_W){1'b0}}, r_min_lam};
            REG_MIN_KSH:  prdata = {{(32-CNT_W){1'b0}}, r_min_ksh};
            REG_PRESCALE: prdata = r_prescale;
            default:      prdata = '0;
        endcase
    end

    // The front end takes items and drops the ones that cause no work.
    ddof_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_op        (i_operation),
        .i_mom       ({i_mom_x, i_mom_y, i_mom_z}),
        .i_last      (i_last_daughter),
        .i_data_mode (r_mode),
        .i_pop       (q_pop),
        .o_busy      (busy),
        .o_avail     (q_avail),
        .o_head      (q_head)
    );

    // The back end owns the daughter table and all per-event state.
    ddof_back #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_avail     (q_avail),
        .i_head      (q_head),
        .o_pop       (q_pop),
        .i_data_mode (r_mode),
        .i_min_lam   (r_min_lam),
        .i_min_ksh   (r_min_ksh),
        .i_prescale  (r_prescale),
        .o_result    (res)
    );

    assign o_result_valid   = res.valid;
    assign o_result_kind    = res.kind;
    assign o_kshort_kept    = res.kept;
    assign o_event_accept   = res.accept;
    assign o_lambda_total   = res.lam;
    assign o_kshort_total   = res.ksh;
    assign o_table_overflow = res.ovf;

endmodule
